@@ hdl/shortest_queue_service_dispatcher_defines.svh @@
// Assertion helpers shared by the dispatcher modules.
`ifndef SHORTEST_QUEUE_SERVICE_DISPATCHER_DEFINES_SVH
`define SHORTEST_QUEUE_SERVICE_DISPATCHER_DEFINES_SVH

// Same-cycle implication.
`define SQSD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dispatcher assertion failed");

// Next-cycle implication.
`define SQSD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dispatcher assertion failed");

`endif

@@ hdl/sqsd_pkg.sv @@
package sqsd_pkg;

   localparam int NUM_SERVERS_DEF = 10;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [3:0]  ACTIVE_RESET = 4'd10;
   localparam logic [4:0]  LIMIT_RESET  = 5'd10;
   localparam logic [10:0] STOP_RESET   = 11'd1020;

   localparam logic [15:0] SERVED_MAX = 16'hFFFF;
   localparam logic [23:0] WAIT_MAX   = 24'hFFFFFF;

   localparam logic [1:0] CSR_ACTIVE = 2'd0;
   localparam logic [1:0] CSR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_STOP   = 2'd2;

   typedef enum logic [1:0] {
      FUNC_ARRIVE = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      KIND_ACCEPT    = 3'd0,
      KIND_LATE      = 3'd1,
      KIND_FULL      = 3'd2,
      KIND_COMPLETED = 3'd3,
      KIND_TICK      = 3'd4,
      KIND_CLEARED   = 3'd5
   } kind_type;

   typedef struct packed {
      logic [15:0] id;
      logic [10:0] arrive;
      logic [5:0]  remain;
      logic        started;
      logic [10:0] wait_min;
   } job_type;

   typedef struct packed {
      logic     latch;
      logic     scan_init;
      logic     arr_scan;
      logic     sel_best;
      logic     arr_write;
      logic     clr_step;
      logic     s_inc;
      logic     rd_head;
      logic     t_proc;
      logic     t_start;
      logic     load;
      kind_type kind;
      logic     last;
   } cmd_type;

   typedef struct packed {
      logic       late;
      logic       full;
      logic       s_act_done;
      logic       s_all_done;
      logic       occ_zero;
      logic       done;
      logic       more;
      logic       rsp_xfer;
      logic       rsp_last;
      logic       rsp_pend;
      logic [1:0] func;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARR_CHK,
      ST_ARR_SCAN,
      ST_ARR_SEL,
      ST_ARR_WR,
      ST_TICK_CHK,
      ST_TICK_PROC,
      ST_TICK_RDN,
      ST_TICK_START,
      ST_TICK_EMIT,
      ST_CLR_SCAN,
      ST_OUT
   } state_type;

endpackage

@@ hdl/sqsd_ctrl.sv @@
`include "shortest_queue_service_dispatcher_defines.svh"

module sqsd_ctrl import sqsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.kind  = KIND_ACCEPT;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch     = 1'b1;
               cmd.scan_init = 1'b1;
               case (sts.func)
                  FUNC_ARRIVE: state_in = ST_ARR_CHK;
                  FUNC_TICK:   state_in = ST_TICK_CHK;
                  FUNC_CLEAR:  state_in = ST_CLR_SCAN;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ARR_CHK: begin
            if (sts.late) begin
               cmd.load = 1'b1;
               cmd.kind = KIND_LATE;
               cmd.last = 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_ARR_SCAN;
            end
         end
         ST_ARR_SCAN: begin
            if (sts.s_act_done) begin
               if (sts.full) begin
                  cmd.load = 1'b1;
                  cmd.kind = KIND_FULL;
                  cmd.last = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_ARR_SEL;
               end
            end else begin
               cmd.arr_scan = 1'b1;
            end
         end
         ST_ARR_SEL: begin
            cmd.sel_best = 1'b1;
            state_in     = ST_ARR_WR;
         end
         ST_ARR_WR: begin
            cmd.arr_write = 1'b1;
            cmd.load      = 1'b1;
            cmd.kind      = KIND_ACCEPT;
            cmd.last      = 1'b1;
            state_in      = ST_OUT;
         end
         ST_TICK_CHK: begin
            if (sts.s_act_done) begin
               cmd.load = 1'b1;
               cmd.kind = KIND_TICK;
               cmd.last = 1'b1;
               state_in = ST_OUT;
            end else if (sts.occ_zero) begin
               cmd.s_inc = 1'b1;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = ST_TICK_PROC;
            end
         end
         ST_TICK_PROC: begin
            cmd.t_proc = 1'b1;
            if (sts.done) begin
               state_in = sts.more ? ST_TICK_RDN : ST_TICK_EMIT;
            end else begin
               cmd.s_inc = 1'b1;
               state_in  = ST_TICK_CHK;
            end
         end
         ST_TICK_RDN: begin
            cmd.rd_head = 1'b1;
            state_in    = ST_TICK_START;
         end
         ST_TICK_START: begin
            cmd.t_start = 1'b1;
            state_in    = ST_TICK_EMIT;
         end
         ST_TICK_EMIT: begin
            cmd.load = 1'b1;
            cmd.kind = KIND_COMPLETED;
            state_in = ST_OUT;
         end
         ST_CLR_SCAN: begin
            if (sts.s_all_done) begin
               cmd.load = 1'b1;
               cmd.kind = KIND_CLEARED;
               cmd.last = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         ST_OUT: begin
            if (sts.rsp_xfer) begin
               if (sts.rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.s_inc = 1'b1;
                  state_in  = ST_TICK_CHK;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `SQSD_ASSERT_IMPL(a_out_pending, clock, reset, state_ff == ST_OUT, sts.rsp_pend)
   `SQSD_ASSERT_NEXT(a_load_to_out, clock, reset, cmd.load, state_ff == ST_OUT)
   `SQSD_ASSERT_IMPL(a_busy_no_load, clock, reset, sts.rsp_pend && state_ff != ST_OUT, 1'b0)

endmodule

@@ hdl/sqsd_dp.sv @@
`include "shortest_queue_service_dispatcher_defines.svh"

module sqsd_dp import sqsd_pkg::*; #(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  req_func,
   input  logic [10:0] req_now_minute,
   input  logic [15:0] req_job_id,
   input  logic [5:0]  req_job_length,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_server,
   output logic [15:0] rsp_job_id_res,
   output logic [4:0]  rsp_queue_length,
   output logic [10:0] rsp_wait_minutes,
   output logic [7:0]  rsp_dropped,
   output logic [15:0] rsp_served_total,
   output logic [23:0] rsp_wait_total,
   output logic        rsp_last,
   input  cmd_type     cmd,
   output sts_type     sts
);

   localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int SW = $clog2(NUM_SERVERS + 1);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(NUM_SERVERS * QUEUE_DEPTH);
   localparam int DW = $clog2(NUM_SERVERS * QUEUE_DEPTH + 1);
   localparam int MD = NUM_SERVERS * QUEUE_DEPTH;

   logic [3:0]    active_ff;
   logic [4:0]    limit_ff;
   logic [10:0]   stop_ff;
   logic [10:0]   now_ff;
   logic [15:0]   id_ff;
   logic [5:0]    len_ff;
   logic [SW-1:0] s_ff;
   logic [IW-1:0] best_ff;
   logic [OW-1:0] best_cnt_ff;
   logic [OW-1:0] occ_ff [NUM_SERVERS];
   logic [PW-1:0] head_ff [NUM_SERVERS];
   logic [DW-1:0] drop_ff;
   logic [15:0]   served_ff;
   logic [23:0]   wsum_ff;
   logic [15:0]   done_id_ff;
   logic [10:0]   done_wait_ff;
   job_type       mem [MD];
   job_type       mem_q;

   logic          rsp_valid_ff;
   kind_type      rsp_kind_ff;
   logic [3:0]    rsp_server_ff;
   logic [15:0]   rsp_id_ff;
   logic [4:0]    rsp_qlen_ff;
   logic [10:0]   rsp_wait_ff;
   logic [7:0]    rsp_drop_ff;
   logic          rsp_last_ff;

   logic [IW-1:0] s_idx;
   logic [OW-1:0] occ_cur;
   logic [PW-1:0] head_cur;
   logic [5:0]    act_ext;
   logic [SW-1:0] act;
   logic [6:0]    limit_ext;
   logic [PW+1:0] tail_sum;
   logic [PW-1:0] tail_ptr;
   logic [PW-1:0] head_nxt;
   logic [AW-1:0] head_addr;
   logic [AW-1:0] tail_addr;
   logic [5:0]    rem_dec;
   logic          done;
   logic          start_lone;
   logic [10:0]   wcalc;
   logic          wadd;
   logic [24:0]   wsum_add;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   job_type       wr_data;
   logic          rsp_xfer;
   logic [OW-1:0] qlen_new;

   assign s_idx    = s_ff[IW-1:0];
   assign occ_cur  = occ_ff[s_idx];
   assign head_cur = head_ff[s_idx];

   always_comb begin
      if (active_ff == 4'd0) begin
         act_ext = 6'd1;
      end else if ({2'b00, active_ff} > 6'(NUM_SERVERS)) begin
         act_ext = 6'(NUM_SERVERS);
      end else begin
         act_ext = {2'b00, active_ff};
      end
      act = SW'(act_ext);
      limit_ext = ({2'b00, limit_ff} > 7'(QUEUE_DEPTH)) ? 7'(QUEUE_DEPTH) : {2'b00, limit_ff};
   end

   always_comb begin
      tail_sum = (PW+2)'(head_cur) + (PW+2)'(occ_cur);
      if (tail_sum >= (PW+2)'(QUEUE_DEPTH)) begin
         tail_ptr = PW'(tail_sum - (PW+2)'(QUEUE_DEPTH));
      end else begin
         tail_ptr = PW'(tail_sum);
      end
      if ((PW+1)'(head_cur) + (PW+1)'(1) >= (PW+1)'(QUEUE_DEPTH)) begin
         head_nxt = '0;
      end else begin
         head_nxt = head_cur + PW'(1);
      end
      head_addr = AW'(s_idx) * AW'(QUEUE_DEPTH) + AW'(head_cur);
      tail_addr = AW'(s_idx) * AW'(QUEUE_DEPTH) + AW'(tail_ptr);
   end

   always_comb begin
      rem_dec    = (mem_q.remain == 6'd0) ? 6'd0 : mem_q.remain - 6'd1;
      done       = (rem_dec == 6'd0);
      start_lone = (occ_cur == OW'(1)) && !mem_q.started;
      wcalc      = (now_ff >= mem_q.arrive) ? now_ff - mem_q.arrive : 11'd0;
      wadd       = (cmd.t_proc && !done && start_lone) || cmd.t_start;
      wsum_add   = {1'b0, wsum_ff} + 25'(wcalc);
      qlen_new   = occ_cur + OW'(1);
      rsp_xfer   = rsp_valid_ff && !rsp_stall;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = head_addr;
      wr_data = mem_q;
      if (cmd.arr_write) begin
         wr_en            = 1'b1;
         wr_addr          = tail_addr;
         wr_data.id       = id_ff;
         wr_data.arrive   = now_ff;
         wr_data.remain   = (len_ff == 6'd0) ? 6'd1 : len_ff;
         wr_data.started  = 1'b0;
         wr_data.wait_min = 11'd0;
      end else if (cmd.t_proc && !done) begin
         wr_en          = 1'b1;
         wr_data.remain = rem_dec;
         if (start_lone) begin
            wr_data.started  = 1'b1;
            wr_data.wait_min = wcalc;
         end
      end else if (cmd.t_start) begin
         wr_en            = 1'b1;
         wr_data.started  = 1'b1;
         wr_data.wait_min = wcalc;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_head) begin
         mem_q <= mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         now_ff  <= req_now_minute;
         id_ff   <= req_job_id;
         len_ff  <= req_job_length;
      end
      if (cmd.arr_scan) begin
         if (s_ff == '0 || occ_cur < best_cnt_ff) begin
            best_ff     <= s_idx;
            best_cnt_ff <= occ_cur;
         end
      end
      if (cmd.t_proc && done) begin
         done_id_ff   <= mem_q.id;
         done_wait_ff <= mem_q.started ? mem_q.wait_min : 11'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         limit_ff  <= LIMIT_RESET;
         stop_ff   <= STOP_RESET;
         s_ff      <= '0;
         drop_ff   <= '0;
         served_ff <= '0;
         wsum_ff   <= '0;
         for (int i = 0; i < NUM_SERVERS; i++) begin
            occ_ff[i]  <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ACTIVE: active_ff <= csr_wdata[3:0];
               CSR_LIMIT:  limit_ff  <= csr_wdata[4:0];
               CSR_STOP:   stop_ff   <= csr_wdata;
               default:    ;
            endcase
         end
         if (cmd.scan_init) begin
            s_ff    <= '0;
            drop_ff <= '0;
         end
         if (cmd.arr_scan || cmd.s_inc) begin
            s_ff <= s_ff + SW'(1);
         end
         if (cmd.sel_best) begin
            s_ff <= SW'(best_ff);
         end
         if (cmd.arr_write) begin
            occ_ff[s_idx] <= qlen_new;
         end
         if (cmd.clr_step) begin
            drop_ff        <= drop_ff + DW'(occ_cur);
            occ_ff[s_idx]  <= '0;
            head_ff[s_idx] <= '0;
            s_ff           <= s_ff + SW'(1);
         end
         if (cmd.t_proc && done) begin
            occ_ff[s_idx]  <= occ_cur - OW'(1);
            head_ff[s_idx] <= head_nxt;
            if (served_ff != SERVED_MAX) begin
               served_ff <= served_ff + 16'd1;
            end
         end
         if (wadd) begin
            wsum_ff <= (wsum_add > {1'b0, WAIT_MAX}) ? WAIT_MAX : wsum_add[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_kind_ff   <= cmd.kind;
         rsp_last_ff   <= cmd.last;
         rsp_server_ff <= 4'd0;
         rsp_id_ff     <= 16'd0;
         rsp_qlen_ff   <= 5'd0;
         rsp_wait_ff   <= 11'd0;
         rsp_drop_ff   <= 8'd0;
         case (cmd.kind)
            KIND_ACCEPT: begin
               rsp_server_ff <= 4'(s_idx);
               rsp_id_ff     <= id_ff;
               rsp_qlen_ff   <= 5'(qlen_new);
            end
            KIND_LATE, KIND_FULL: begin
               rsp_id_ff <= id_ff;
            end
            KIND_COMPLETED: begin
               rsp_server_ff <= 4'(s_idx);
               rsp_id_ff     <= done_id_ff;
               rsp_wait_ff   <= done_wait_ff;
            end
            KIND_CLEARED: begin
               rsp_drop_ff <= 8'(drop_ff);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      sts            = '0;
      sts.late       = (now_ff >= stop_ff);
      sts.full       = (7'(best_cnt_ff) >= limit_ext);
      sts.s_act_done = (s_ff == act);
      sts.s_all_done = (s_ff == SW'(NUM_SERVERS));
      sts.occ_zero   = (occ_cur == '0);
      sts.done       = done;
      sts.more       = (occ_cur > OW'(1));
      sts.rsp_xfer   = rsp_xfer;
      sts.rsp_last   = rsp_last_ff;
      sts.rsp_pend   = rsp_valid_ff;
      sts.func       = req_func;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_server       = rsp_server_ff;
   assign rsp_job_id_res   = rsp_id_ff;
   assign rsp_queue_length = rsp_qlen_ff;
   assign rsp_wait_minutes = rsp_wait_ff;
   assign rsp_dropped      = rsp_drop_ff;
   assign rsp_served_total = served_ff;
   assign rsp_wait_total   = wsum_ff;
   assign rsp_last         = rsp_last_ff;

   `SQSD_ASSERT_IMPL(a_mid_is_done, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_kind_ff == KIND_COMPLETED)
   `SQSD_ASSERT_IMPL(a_accept_qlen, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_ACCEPT, rsp_qlen_ff != 5'd0)
   `SQSD_ASSERT_IMPL(a_pop_nonempty, clock, reset, cmd.t_proc, occ_cur != '0)

endmodule

@@ hdl/shortest_queue_service_dispatcher.sv @@
// Join-shortest-queue dispatcher over a bank of server FIFOs.
// Request channel (req_valid/req_stall): one item per transfer. func selects
// arrival, one-minute tick or clear; code three is dropped with no response.
// Response channel (rsp_valid/rsp_stall): an arrival or clear gives one
// response; a tick gives one completion response per finished job, then a
// tick-done response. rsp_last marks the final response of an item.
// CSR channel (csr_valid/csr_ready): ready is always high; index 0 active
// servers, 1 queue limit, 2 stop minute. Write only while the block is idle.
// Arrival: check the stop minute, scan the active servers, select the
// shortest queue and write the job. Clear steps through every server.
// Tick steps through the servers in turn, reading a busy server's head job
// from the single-port job store. One item is in flight at a time.
// A stalled response holds its register and the block waits; req_stall stays
// high until the item's last response transfers.
// Reset: all queues empty, counters zero, CSRs at their defaults.
module shortest_queue_service_dispatcher import sqsd_pkg::*; #(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [10:0] req_now_minute,
   input  logic [15:0] req_job_id,
   input  logic [5:0]  req_job_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_server,
   output logic [15:0] rsp_job_id_res,
   output logic [4:0]  rsp_queue_length,
   output logic [10:0] rsp_wait_minutes,
   output logic [7:0]  rsp_dropped,
   output logic [15:0] rsp_served_total,
   output logic [23:0] rsp_wait_total,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sqsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sqsd_dp #(
      .NUM_SERVERS (NUM_SERVERS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_now_minute   (req_now_minute),
      .req_job_id       (req_job_id),
      .req_job_length   (req_job_length),
      .csr_valid        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_server       (rsp_server),
      .rsp_job_id_res   (rsp_job_id_res),
      .rsp_queue_length (rsp_queue_length),
      .rsp_wait_minutes (rsp_wait_minutes),
      .rsp_dropped      (rsp_dropped),
      .rsp_served_total (rsp_served_total),
      .rsp_wait_total   (rsp_wait_total),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule
